// File: rtl/mlr_pkg.sv
// Midpoint line rasteriser: shared constants, register indexes and types.
// No dependencies; every other file of the block uses this package.
`default_nettype none

package mlr_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int CLIP_BITS      = 11;
    localparam int CFG_IDX_BITS   = 2;

    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_X_MAX = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_CLIP_Y_MAX = 2'd1;

    localparam logic [CLIP_BITS-1:0] CLIP_X_RESET = 11'd1919;
    localparam logic [CLIP_BITS-1:0] CLIP_Y_RESET = 11'd1039;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef struct packed {
        logic minor_neg;
        logic major_neg;
        logic y_major;
    } t_mode;

endpackage

`default_nettype wire

// File: rtl/mlr_if.sv
// Midpoint line rasteriser: request, pixel and configuration channels.
// Depends on mlr_pkg for default widths.
`default_nettype none

interface mlr_req_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [COORD_BITS-1:0] x_start;
    logic signed [COORD_BITS-1:0] y_start;
    logic signed [COORD_BITS-1:0] x_end;
    logic signed [COORD_BITS-1:0] y_end;

    modport source (output valid, req_type, x_start, y_start, x_end, y_end, input ready);
    modport sink   (input valid, req_type, x_start, y_start, x_end, y_end, output ready);
endinterface

interface mlr_pix_if #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] pix_x;
    logic signed [COORD_BITS-1:0] pix_y;
    logic                         visible;
    logic                         last;

    modport source (output valid, pix_x, pix_y, visible, last, input ready);
    modport sink   (input valid, pix_x, pix_y, visible, last, output ready);
endinterface

interface mlr_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [mlr_pkg::CFG_IDX_BITS-1:0]     index;
    logic [mlr_pkg::CLIP_BITS-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/mlr_setup.sv
// Midpoint line rasteriser: line set-up logic (octant, first decision, increments).
// Depends on mlr_pkg.
`default_nettype none

module mlr_setup #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0] i_x_start,
    input  wire logic signed [COORD_BITS-1:0] i_y_start,
    input  wire logic signed [COORD_BITS-1:0] i_x_end,
    input  wire logic signed [COORD_BITS-1:0] i_y_end,
    output logic signed [COORD_BITS-1:0]      o_major_end,
    output logic signed [COORD_BITS+2:0]      o_decision,
    output logic signed [COORD_BITS+1:0]      o_diag_inc,
    output logic signed [COORD_BITS:0]        o_straight_inc,
    output mlr_pkg::t_mode                    o_mode,
    output logic                              o_active
);
    import mlr_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int IW = COORD_BITS + 2;
    localparam int TW = COORD_BITS + 3;

    logic signed [DW-1:0] dx, dy, abs_dx, abs_dy, maj, mnr_raw, mnr_abs, mnr;
    logic signed [TW-1:0] twice;
    logic signed [TW-1:0] half;
    logic                 y_major;

    always_comb begin
        dx      = DW'(i_x_end) - DW'(i_x_start);
        dy      = DW'(i_y_end) - DW'(i_y_start);
        abs_dx  = dx[DW-1] ? -dx : dx;
        abs_dy  = dy[DW-1] ? -dy : dy;
        y_major = abs_dy > abs_dx;

        maj         = y_major ? -dy : dx;
        mnr_raw     = y_major ? dx : dy;
        o_major_end = y_major ? i_y_end : i_x_end;

        o_mode.y_major   = y_major;
        o_mode.major_neg = y_major ? dy[DW-1] : dx[DW-1];
        o_mode.minor_neg = mnr_raw[DW-1];

        mnr_abs = mnr_raw[DW-1] ? -mnr_raw : mnr_raw;
        mnr     = (maj > 0) ? mnr_abs : -mnr_abs;

        // halve toward zero
        twice = (TW'(mnr) <<< 1) - TW'(maj);
        half  = twice >>> 1;
        if (twice[TW-1] && twice[0]) begin
            o_decision = half + TW'(1);
        end else begin
            o_decision = half;
        end

        o_diag_inc     = IW'(mnr) - IW'(maj);
        o_straight_inc = mnr;
        o_active       = maj != '0;
    end

endmodule

`default_nettype wire

// File: rtl/mlr_step.sv
// Midpoint line rasteriser: one pixel step (decision test, advance, clip, end test).
// Depends on mlr_pkg.
`default_nettype none

module mlr_step #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic signed [COORD_BITS-1:0]     i_cur_x,
    input  wire logic signed [COORD_BITS-1:0]     i_cur_y,
    input  wire logic signed [COORD_BITS-1:0]     i_major_end,
    input  wire logic signed [COORD_BITS+2:0]     i_decision,
    input  wire logic signed [COORD_BITS+1:0]     i_diag_inc,
    input  wire logic signed [COORD_BITS:0]       i_straight_inc,
    input  wire mlr_pkg::t_mode                   i_mode,
    input  wire logic [mlr_pkg::CLIP_BITS-1:0]    i_clip_x_max,
    input  wire logic [mlr_pkg::CLIP_BITS-1:0]    i_clip_y_max,
    output logic signed [COORD_BITS-1:0]          o_next_x,
    output logic signed [COORD_BITS-1:0]          o_next_y,
    output logic signed [COORD_BITS+2:0]          o_next_decision,
    output logic                                  o_visible,
    output logic                                  o_last
);
    import mlr_pkg::*;

    localparam int TW = COORD_BITS + 3;
    localparam int VW = ((COORD_BITS > CLIP_BITS) ? COORD_BITS : CLIP_BITS) + 1;

    logic [COORD_BITS-1:0] cur_maj, cur_min, next_maj, next_min, new_min;
    logic                  ge_test, take_diag;
    logic signed [VW-1:0]  vx, vy, lim_x, lim_y;

    always_comb begin
        cur_maj  = i_mode.y_major ? i_cur_y : i_cur_x;
        cur_min  = i_mode.y_major ? i_cur_x : i_cur_y;
        next_maj = i_mode.major_neg ? cur_maj - COORD_BITS'(1) : cur_maj + COORD_BITS'(1);
        next_min = i_mode.minor_neg ? cur_min - COORD_BITS'(1) : cur_min + COORD_BITS'(1);
        o_last   = next_maj == i_major_end;

        ge_test   = i_mode.y_major ? i_mode.major_neg : !i_mode.major_neg;
        take_diag = ge_test ? !i_decision[TW-1]
                            : (i_decision[TW-1] || (i_decision == '0));

        o_next_decision = i_decision + (take_diag ? TW'(i_diag_inc) : TW'(i_straight_inc));
        new_min         = take_diag ? next_min : cur_min;
        o_next_x        = i_mode.y_major ? new_min : next_maj;
        o_next_y        = i_mode.y_major ? next_maj : new_min;

        vx    = VW'(i_cur_x);
        vy    = VW'(i_cur_y);
        lim_x = VW'($signed({1'b0, i_clip_x_max}));
        lim_y = VW'($signed({1'b0, i_clip_y_max}));
        o_visible = (vx >= VW'(1)) && (vx <= lim_x) && (vy >= VW'(1)) && (vy <= lim_y);
    end

endmodule

`default_nettype wire

// File: rtl/midpoint_line_rasterizer_core.sv
// Midpoint line rasteriser top level: request register, line state, pixel register.
// Depends on mlr_pkg, mlr_if, mlr_setup and mlr_step.
`default_nettype none

// A load item (req_type 0) sets up a line from start to end and returns nothing;
// each step item (req_type 1) returns the next pixel, start included, end excluded,
// with last set on the final one and visible set inside 1..clip max on both axes.
// Steps with no line loaded return nothing. The block takes one item every clock
// while ready is high: each item is held in the request register, and a step's pixel
// enters the result register when that item is processed, which waits for the result
// register to be free. Ready drops only while the result register holds an untaken
// pixel and the waiting item is a step on an active line.
// Clip limits are written on the configuration channel (index 0 x, index 1 y); the
// user must write them only while the block is idle, which the block does not enforce.
module midpoint_line_rasterizer_core #(
    parameter int COORD_BITS = mlr_pkg::COORD_BITS_DEF
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mlr_req_if.sink   i_req,
    mlr_pix_if.source o_pix,
    mlr_cfg_if.sink   i_cfg
);
    import mlr_pkg::*;

    localparam int TW = COORD_BITS + 3;

    logic                         r_s1_valid;
    logic                         r_s1_req_type;
    logic signed [COORD_BITS-1:0] r_s1_x_start, r_s1_y_start, r_s1_x_end, r_s1_y_end;

    logic signed [COORD_BITS-1:0] r_cur_x, r_cur_y, r_major_end;
    logic signed [TW-1:0]         r_decision;
    logic signed [COORD_BITS+1:0] r_diag_inc;
    logic signed [COORD_BITS:0]   r_straight_inc;
    t_mode                        r_mode;
    logic                         r_active;

    logic [CLIP_BITS-1:0]         r_clip_x_max, r_clip_y_max;

    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_pix_x, r_pix_y;
    logic                         r_visible, r_last;
    logic                         n_out_valid;

    logic signed [COORD_BITS-1:0] su_major_end;
    logic signed [TW-1:0]         su_decision;
    logic signed [COORD_BITS+1:0] su_diag_inc;
    logic signed [COORD_BITS:0]   su_straight_inc;
    t_mode                        su_mode;
    logic                         su_active;

    logic signed [COORD_BITS-1:0] st_next_x, st_next_y;
    logic signed [TW-1:0]         st_next_decision;
    logic                         st_visible, st_last;

    logic out_free, produces, proc;

    mlr_setup #(.COORD_BITS(COORD_BITS)) u_setup (
        .i_x_start      (r_s1_x_start),
        .i_y_start      (r_s1_y_start),
        .i_x_end        (r_s1_x_end),
        .i_y_end        (r_s1_y_end),
        .o_major_end    (su_major_end),
        .o_decision     (su_decision),
        .o_diag_inc     (su_diag_inc),
        .o_straight_inc (su_straight_inc),
        .o_mode         (su_mode),
        .o_active       (su_active)
    );

    mlr_step #(.COORD_BITS(COORD_BITS)) u_step (
        .i_cur_x         (r_cur_x),
        .i_cur_y         (r_cur_y),
        .i_major_end     (r_major_end),
        .i_decision      (r_decision),
        .i_diag_inc      (r_diag_inc),
        .i_straight_inc  (r_straight_inc),
        .i_mode          (r_mode),
        .i_clip_x_max    (r_clip_x_max),
        .i_clip_y_max    (r_clip_y_max),
        .o_next_x        (st_next_x),
        .o_next_y        (st_next_y),
        .o_next_decision (st_next_decision),
        .o_visible       (st_visible),
        .o_last          (st_last)
    );

    always_comb begin
        out_free    = !r_out_valid || o_pix.ready;
        produces    = (r_s1_req_type == REQ_STEP) && r_active;
        proc        = r_s1_valid && (!produces || out_free);
        n_out_valid = (r_out_valid && !o_pix.ready) || (proc && produces);
    end

    assign i_req.ready   = !r_s1_valid || proc;
    assign i_cfg.ready   = 1'b1;
    assign o_pix.valid   = r_out_valid;
    assign o_pix.pix_x   = r_pix_x;
    assign o_pix.pix_y   = r_pix_y;
    assign o_pix.visible = r_visible;
    assign o_pix.last    = r_last;

    // request register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_valid <= i_req.valid;
        end
        if (i_req.valid && i_req.ready) begin
            r_s1_req_type <= i_req.req_type;
            r_s1_x_start  <= i_req.x_start;
            r_s1_y_start  <= i_req.y_start;
            r_s1_x_end    <= i_req.x_end;
            r_s1_y_end    <= i_req.y_end;
        end
    end

    // line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x        <= '0;
            r_cur_y        <= '0;
            r_major_end    <= '0;
            r_decision     <= '0;
            r_diag_inc     <= '0;
            r_straight_inc <= '0;
            r_mode         <= '0;
            r_active       <= 1'b0;
        end else if (proc) begin
            if (r_s1_req_type == REQ_LOAD) begin
                r_cur_x        <= r_s1_x_start;
                r_cur_y        <= r_s1_y_start;
                r_major_end    <= su_major_end;
                r_decision     <= su_decision;
                r_diag_inc     <= su_diag_inc;
                r_straight_inc <= su_straight_inc;
                r_mode         <= su_mode;
                r_active       <= su_active;
            end else if (r_active) begin
                r_cur_x    <= st_next_x;
                r_cur_y    <= st_next_y;
                r_decision <= st_next_decision;
                r_active   <= !st_last;
            end
        end
    end

    // pixel register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
        if (proc && produces) begin
            r_pix_x   <= r_cur_x;
            r_pix_y   <= r_cur_y;
            r_visible <= st_visible;
            r_last    <= st_last;
        end
    end

    // clip limits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clip_x_max <= CLIP_X_RESET;
            r_clip_y_max <= CLIP_Y_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.index)
                CFG_CLIP_X_MAX: r_clip_x_max <= i_cfg.data;
                CFG_CLIP_Y_MAX: r_clip_y_max <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

endmodule

`default_nettype wire
